// File: rtl/core/gf2pa_pkg.sv
// GF(2) polynomial ALU package: request/response types, opcodes, status codes
// and sequencer state types. No dependencies.

package gf2pa_pkg;

   // Opcodes
   localparam logic [3:0] OP_ADD    = 4'd0;
   localparam logic [3:0] OP_MUL    = 4'd1;
   localparam logic [3:0] OP_DIV    = 4'd2;
   localparam logic [3:0] OP_GCD    = 4'd3;
   localparam logic [3:0] OP_EXTGCD = 4'd4;
   localparam logic [3:0] OP_MOD    = 4'd5;
   localparam logic [3:0] OP_ADDMOD = 4'd6;
   localparam logic [3:0] OP_MULMOD = 4'd7;
   localparam logic [3:0] OP_INV    = 4'd8;
   localparam logic [3:0] OP_DIVMOD = 4'd9;

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_MOD_ZERO = 2'd2;
   localparam logic [1:0] STATUS_NOT_INV  = 2'd3;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0] result_first;
      logic [31:0] result_second;
      logic [31:0] result_third;
      logic [1:0]  status;
   } rsp_type;

   // Sequencer: which shift unit is running
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DSCAN,
      ST_DSTEP,
      ST_MSTEP,
      ST_ROUTE
   } state_type;

   // Program step: what to do when the running unit finishes
   typedef enum logic [3:0] {
      PH_DIV,
      PH_MUL,
      PH_MODRED,
      PH_MMUL,
      PH_INV_PRE,
      PH_EUC_TEST,
      PH_EUC_DIV,
      PH_EUC_MUL,
      PH_INV_POST
   } phase_type;

endpackage

// File: rtl/core/gf2_polynomial_alu_unit.sv
// GF(2) polynomial ALU top level: bit-serial divider, bit-serial multiplier
// and the sequencer that chains them. Depends on gf2pa_pkg.
//
// Usage: drive req_data and raise start; the request is taken at a clock
// edge where start is high and busy is low. One response comes back per
// request, on rsp_data for one cycle with rsp_strobe high; the receiver
// cannot stall it. The modulus register is written through csr_write_en /
// csr_write_data only while the unit is idle; the block does not enforce it.
// Operation sequences (W = WORD_BITS), all one-bit-per-cycle shift loops:
//   add, zero-divisor and unset-modulus errors, unused opcodes: no shift loop.
//   mul: multiplier shift register, W multiplier bits.
//   div, mod, addmod: divisor degree scan, then W dividend bits.
//   mulmod: multiply, then the 2W-bit product is reduced bit by bit.
//   gcd / extgcd / inverse / divmod: one Euclid pass per remainder, each a
//   division plus, except for gcd, a coefficient multiply, with
//   at most about W passes; the Euclid loop sets the worst case.
// A new request is accepted in the cycle the previous response is shown.
// Reset clears the sequencer, the response strobe and the modulus (unset).

module gf2_polynomial_alu_unit #(
   parameter int WORD_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gf2pa_pkg::req_type req_data,
   output logic              rsp_strobe,
   output gf2pa_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [31:0]       csr_write_data
);

   localparam int W    = WORD_BITS;
   localparam int W2   = 2 * WORD_BITS;
   localparam int DEGW = $clog2(WORD_BITS);
   localparam int CNTW = $clog2(2 * WORD_BITS + 1);

   // Registers
   gf2pa_pkg::state_type state_ff, state_in;
   gf2pa_pkg::phase_type phase_ff, phase_in;
   logic [3:0]      op_ff, op_in;
   logic [W-1:0]    a_ff, a_in;
   logic [W-1:0]    mod_ff, mod_in;
   logic [W-1:0]    x_ff, x_in, y_ff, y_in;
   logic [W-1:0]    u0_ff, u0_in, u1_ff, u1_in, v0_ff, v0_in, v1_ff, v1_in;
   logic [W2-1:0]   dvd_ff, dvd_in;
   logic [W-1:0]    dsr_ff, dsr_in, scan_ff, scan_in;
   logic [W-1:0]    rem_ff, rem_in, quo_ff, quo_in;
   logic [DEGW-1:0] deg_ff, deg_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]    mx_ff, mx_in, mx2_ff, mx2_in, my_ff, my_in;
   logic [W2-1:0]   prod_ff, prod_in;
   logic [W-1:0]    prod2_ff, prod2_in;
   gf2pa_pkg::rsp_type rsp_ff, rsp_in;
   logic            strobe_ff, strobe_in;

   // Dispatch decisions
   logic            accept;
   logic [W-1:0]    req_a, req_b;
   logic            go_div, div_long, go_mul, go_route, fin;
   logic [W2-1:0]   div_dvd;
   logic [W-1:0]    div_dsr, mul_x, mul_x2, mul_y;
   logic            euc_init, euc_adv, euc_coef;
   logic [W-1:0]    euc_x, euc_y;
   gf2pa_pkg::rsp_type fin_rsp;
   gf2pa_pkg::phase_type ph_sel;

   // Shift step terms
   logic [W-1:0]    dstep_t;
   logic            dstep_hit;
   logic            mstep_bit;
   logic            scan_done;
   logic            cnt_last;

   assign accept    = start && (state_ff == gf2pa_pkg::ST_IDLE);
   assign req_a     = W'(req_data.operand_a);
   assign req_b     = W'(req_data.operand_b);
   assign dstep_t   = {rem_ff[W-2:0], dvd_ff[W2-1]};
   assign dstep_hit = dstep_t[deg_ff];
   assign mstep_bit = my_ff[W-1];
   assign scan_done = scan_ff[W-1] || (scan_ff == '0);
   assign cnt_last  = (cnt_ff == CNTW'(1));

   // Dispatch: start requests and chain units at the end of each step
   always_comb begin
      go_div   = 1'b0;
      div_long = 1'b0;
      div_dvd  = '0;
      div_dsr  = '0;
      go_mul   = 1'b0;
      mul_x    = '0;
      mul_x2   = '0;
      mul_y    = '0;
      go_route = 1'b0;
      fin      = 1'b0;
      fin_rsp  = '0;
      euc_init = 1'b0;
      euc_adv  = 1'b0;
      euc_coef = 1'b0;
      euc_x    = '0;
      euc_y    = '0;
      ph_sel   = phase_ff;
      case (state_ff)
         gf2pa_pkg::ST_IDLE: begin
            if (accept) begin
               if ((req_data.opcode inside {[gf2pa_pkg::OP_MOD:gf2pa_pkg::OP_DIVMOD]})
                   && (mod_ff == '0)) begin
                  fin            = 1'b1;
                  fin_rsp.status = gf2pa_pkg::STATUS_MOD_ZERO;
               end else begin
                  case (req_data.opcode)
                     gf2pa_pkg::OP_ADD: begin
                        fin                  = 1'b1;
                        fin_rsp.result_first = 32'(req_a ^ req_b);
                     end
                     gf2pa_pkg::OP_MUL: begin
                        go_mul = 1'b1;
                        mul_x  = req_a;
                        mul_y  = req_b;
                        ph_sel = gf2pa_pkg::PH_MUL;
                     end
                     gf2pa_pkg::OP_DIV: begin
                        if (req_b == '0) begin
                           fin                  = 1'b1;
                           fin_rsp.result_first = 32'({W{1'b1}});
                           fin_rsp.status       = gf2pa_pkg::STATUS_DIV_ZERO;
                        end else begin
                           go_div  = 1'b1;
                           div_dvd = {req_a, {W{1'b0}}};
                           div_dsr = req_b;
                           ph_sel  = gf2pa_pkg::PH_DIV;
                        end
                     end
                     gf2pa_pkg::OP_GCD, gf2pa_pkg::OP_EXTGCD: begin
                        euc_init = 1'b1;
                        euc_x    = req_a;
                        euc_y    = req_b;
                        go_route = 1'b1;
                        ph_sel   = gf2pa_pkg::PH_EUC_TEST;
                     end
                     gf2pa_pkg::OP_MOD: begin
                        go_div  = 1'b1;
                        div_dvd = {req_a, {W{1'b0}}};
                        div_dsr = mod_ff;
                        ph_sel  = gf2pa_pkg::PH_MODRED;
                     end
                     gf2pa_pkg::OP_ADDMOD: begin
                        go_div  = 1'b1;
                        div_dvd = {req_a ^ req_b, {W{1'b0}}};
                        div_dsr = mod_ff;
                        ph_sel  = gf2pa_pkg::PH_MODRED;
                     end
                     gf2pa_pkg::OP_MULMOD: begin
                        go_mul = 1'b1;
                        mul_x  = req_a;
                        mul_y  = req_b;
                        ph_sel = gf2pa_pkg::PH_MMUL;
                     end
                     gf2pa_pkg::OP_INV: begin
                        go_div  = 1'b1;
                        div_dvd = {req_a, {W{1'b0}}};
                        div_dsr = mod_ff;
                        ph_sel  = gf2pa_pkg::PH_INV_PRE;
                     end
                     gf2pa_pkg::OP_DIVMOD: begin
                        go_div  = 1'b1;
                        div_dvd = {req_b, {W{1'b0}}};
                        div_dsr = mod_ff;
                        ph_sel  = gf2pa_pkg::PH_INV_PRE;
                     end
                     default: begin
                        fin = 1'b1;
                     end
                  endcase
               end
            end
         end
         gf2pa_pkg::ST_ROUTE: begin
            case (phase_ff)
               gf2pa_pkg::PH_DIV: begin
                  fin                   = 1'b1;
                  fin_rsp.result_first  = 32'(quo_ff);
                  fin_rsp.result_second = 32'(rem_ff);
               end
               gf2pa_pkg::PH_MUL: begin
                  fin                   = 1'b1;
                  fin_rsp.result_first  = 32'(prod_ff[W-1:0]);
                  fin_rsp.result_second = 32'(prod_ff[W2-1:W]);
               end
               gf2pa_pkg::PH_MODRED: begin
                  fin                  = 1'b1;
                  fin_rsp.result_first = 32'(rem_ff);
               end
               gf2pa_pkg::PH_MMUL: begin
                  go_div   = 1'b1;
                  div_long = 1'b1;
                  div_dvd  = prod_ff;
                  div_dsr  = mod_ff;
                  ph_sel   = gf2pa_pkg::PH_MODRED;
               end
               gf2pa_pkg::PH_INV_PRE: begin
                  euc_init = 1'b1;
                  euc_x    = rem_ff;
                  euc_y    = mod_ff;
                  go_route = 1'b1;
                  ph_sel   = gf2pa_pkg::PH_EUC_TEST;
               end
               gf2pa_pkg::PH_EUC_TEST: begin
                  if (y_ff == '0) begin
                     if (op_ff == gf2pa_pkg::OP_GCD) begin
                        fin                  = 1'b1;
                        fin_rsp.result_first = 32'(x_ff);
                     end else if (op_ff == gf2pa_pkg::OP_EXTGCD) begin
                        fin                   = 1'b1;
                        fin_rsp.result_first  = 32'(x_ff);
                        fin_rsp.result_second = 32'(u0_ff);
                        fin_rsp.result_third  = 32'(v0_ff);
                     end else if (x_ff != W'(1)) begin
                        fin            = 1'b1;
                        fin_rsp.status = gf2pa_pkg::STATUS_NOT_INV;
                     end else begin
                        go_div  = 1'b1;
                        div_dvd = {u0_ff, {W{1'b0}}};
                        div_dsr = mod_ff;
                        ph_sel  = gf2pa_pkg::PH_INV_POST;
                     end
                  end else begin
                     go_div  = 1'b1;
                     div_dvd = {x_ff, {W{1'b0}}};
                     div_dsr = y_ff;
                     ph_sel  = gf2pa_pkg::PH_EUC_DIV;
                  end
               end
               gf2pa_pkg::PH_EUC_DIV: begin
                  if (op_ff == gf2pa_pkg::OP_GCD) begin
                     euc_adv  = 1'b1;
                     go_route = 1'b1;
                     ph_sel   = gf2pa_pkg::PH_EUC_TEST;
                  end else begin
                     go_mul = 1'b1;
                     mul_x  = u1_ff;
                     mul_x2 = v1_ff;
                     mul_y  = quo_ff;
                     ph_sel = gf2pa_pkg::PH_EUC_MUL;
                  end
               end
               gf2pa_pkg::PH_EUC_MUL: begin
                  euc_adv  = 1'b1;
                  euc_coef = 1'b1;
                  go_route = 1'b1;
                  ph_sel   = gf2pa_pkg::PH_EUC_TEST;
               end
               gf2pa_pkg::PH_INV_POST: begin
                  if (op_ff == gf2pa_pkg::OP_INV) begin
                     fin                  = 1'b1;
                     fin_rsp.result_first = 32'(rem_ff);
                  end else begin
                     go_mul = 1'b1;
                     mul_x  = a_ff;
                     mul_y  = rem_ff;
                     ph_sel = gf2pa_pkg::PH_MMUL;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      phase_in = ph_sel;
      case (state_ff)
         gf2pa_pkg::ST_IDLE, gf2pa_pkg::ST_ROUTE: begin
            if (go_div) begin
               state_in = gf2pa_pkg::ST_DSCAN;
            end else if (go_mul) begin
               state_in = gf2pa_pkg::ST_MSTEP;
            end else if (go_route) begin
               state_in = gf2pa_pkg::ST_ROUTE;
            end else begin
               state_in = gf2pa_pkg::ST_IDLE;
            end
         end
         gf2pa_pkg::ST_DSCAN: begin
            if (scan_done) begin
               state_in = gf2pa_pkg::ST_DSTEP;
            end
         end
         gf2pa_pkg::ST_DSTEP, gf2pa_pkg::ST_MSTEP: begin
            if (cnt_last) begin
               state_in = gf2pa_pkg::ST_ROUTE;
            end
         end
         default: begin
            state_in = gf2pa_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      op_in     = op_ff;
      a_in      = a_ff;
      mod_in    = mod_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      u0_in     = u0_ff;
      u1_in     = u1_ff;
      v0_in     = v0_ff;
      v1_in     = v1_ff;
      dvd_in    = dvd_ff;
      dsr_in    = dsr_ff;
      scan_in   = scan_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      deg_in    = deg_ff;
      cnt_in    = cnt_ff;
      mx_in     = mx_ff;
      mx2_in    = mx2_ff;
      my_in     = my_ff;
      prod_in   = prod_ff;
      prod2_in  = prod2_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;

      // modulus register
      if (csr_write_en) begin
         mod_in = W'(csr_write_data);
      end

      // capture request
      if (accept) begin
         op_in = req_data.opcode;
         a_in  = req_a;
      end

      // Euclid bookkeeping
      if (euc_init) begin
         x_in  = euc_x;
         y_in  = euc_y;
         u0_in = W'(1);
         u1_in = '0;
         v0_in = '0;
         v1_in = W'(1);
      end
      if (euc_adv) begin
         x_in = y_ff;
         y_in = rem_ff;
      end
      if (euc_coef) begin
         u0_in = u1_ff;
         u1_in = u0_ff ^ prod_ff[W-1:0];
         v0_in = v1_ff;
         v1_in = v0_ff ^ prod2_ff;
      end

      // load divider
      if (go_div) begin
         dvd_in  = div_dvd;
         dsr_in  = div_dsr;
         scan_in = div_dsr;
         deg_in  = DEGW'(W - 1);
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = div_long ? CNTW'(W2) : CNTW'(W);
      end

      // load multiplier
      if (go_mul) begin
         mx_in    = mul_x;
         mx2_in   = mul_x2;
         my_in    = mul_y;
         prod_in  = '0;
         prod2_in = '0;
         cnt_in   = CNTW'(W);
      end

      // response
      if (fin) begin
         rsp_in    = fin_rsp;
         strobe_in = 1'b1;
      end

      case (state_ff)
         // divisor degree: shift left until the top bit is set
         gf2pa_pkg::ST_DSCAN: begin
            if (!scan_done) begin
               scan_in = {scan_ff[W-2:0], 1'b0};
               deg_in  = deg_ff - DEGW'(1);
            end
         end
         // one dividend bit per cycle, MSB first
         gf2pa_pkg::ST_DSTEP: begin
            rem_in = dstep_hit ? (dstep_t ^ dsr_ff) : dstep_t;
            quo_in = {quo_ff[W-2:0], dstep_hit};
            dvd_in = {dvd_ff[W2-2:0], 1'b0};
            cnt_in = cnt_ff - CNTW'(1);
         end
         // one multiplier bit per cycle, MSB first
         gf2pa_pkg::ST_MSTEP: begin
            prod_in  = {prod_ff[W2-2:0], 1'b0} ^
                       (mstep_bit ? {{W{1'b0}}, mx_ff} : {W2{1'b0}});
            prod2_in = {prod2_ff[W-2:0], 1'b0} ^ (mstep_bit ? mx2_ff : {W{1'b0}});
            my_in    = {my_ff[W-2:0], 1'b0};
            cnt_in   = cnt_ff - CNTW'(1);
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gf2pa_pkg::ST_IDLE;
         phase_ff  <= gf2pa_pkg::PH_DIV;
         strobe_ff <= 1'b0;
         mod_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         strobe_ff <= strobe_in;
         mod_ff    <= mod_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      a_ff     <= a_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      u0_ff    <= u0_in;
      u1_ff    <= u1_in;
      v0_ff    <= v0_in;
      v1_ff    <= v1_in;
      dvd_ff   <= dvd_in;
      dsr_ff   <= dsr_in;
      scan_ff  <= scan_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      deg_ff   <= deg_in;
      cnt_ff   <= cnt_in;
      mx_ff    <= mx_in;
      mx2_ff   <= mx2_in;
      my_ff    <= my_in;
      prod_ff  <= prod_in;
      prod2_ff <= prod2_in;
      rsp_ff   <= rsp_in;
   end

   // Outputs
   always_comb begin
      busy       = (state_ff != gf2pa_pkg::ST_IDLE);
      rsp_strobe = strobe_ff;
      rsp_data   = rsp_ff;
   end

   // Checks
   a_add_one_cycle: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.opcode == gf2pa_pkg::OP_ADD) |=> rsp_strobe)
      else $error("add request did not respond in one cycle");

   a_div_normalized: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gf2pa_pkg::ST_DSTEP) |-> dsr_ff[deg_ff])
      else $error("divisor degree register does not point at leading bit");

   a_rem_below_deg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gf2pa_pkg::ST_DSTEP) |-> ((rem_ff >> deg_ff) == '0))
      else $error("partial remainder degree not below divisor degree");

   a_strobe_pairs: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(rsp_strobe) |-> $past(start && !busy))
      else $error("back-to-back responses without a request between");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gf2pa_pkg::ST_MSTEP) |-> (cnt_ff != '0))
      else $error("multiplier step counter underflow");

endmodule

// File: verif/tb_gf2_polynomial_alu_unit.sv
// Self-checking testbench for gf2_polynomial_alu_unit: directed and random requests
// checked against a behavioral GF(2) polynomial predictor. Depends on gf2pa_pkg and gf2_polynomial_alu_unit.
`timescale 1ns / 1ps

module tb_gf2_polynomial_alu_unit;

   localparam int W = 32;
   localparam longint CYCLE_LIMIT = 20000000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   gf2pa_pkg::req_type req_data;
   logic rsp_strobe;
   gf2pa_pkg::rsp_type rsp_data;
   logic csr_write_en;
   logic [31:0] csr_write_data;

   gf2_polynomial_alu_unit #(.WORD_BITS(W)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   // predictor state and expected responses
   logic [31:0] modulus_reg;
   gf2pa_pkg::rsp_type expected_rsp_q[$];
   int error_count = 0;
   int rsp_count = 0;
   int req_count = 0;
   int send_idle_pct = 0;
   longint cycle_count = 0;
   int op_hits[16];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------- polynomial helpers ----------------
   function automatic int poly_degree(logic [63:0] p);
      int d;
      d = -1;
      for (int i = 0; i < 64; i++)
         if (p[i]) d = i;
      return d;
   endfunction

   function automatic void poly_divide(logic [31:0] a, logic [31:0] b,
                                       output logic [31:0] q, output logic [31:0] r);
      int db;
      int s;
      db = poly_degree(b);
      q = '0;
      r = a;
      while (r != 0 && poly_degree(r) >= db) begin
         s = poly_degree(r) - db;
         q[s] = 1'b1;
         r ^= b << s;
      end
   endfunction

   function automatic logic [31:0] poly_rem(logic [31:0] a, logic [31:0] n);
      logic [31:0] q, r;
      poly_divide(a, n, q, r);
      return r;
   endfunction

   function automatic logic [63:0] clmul(logic [31:0] a, logic [31:0] b);
      logic [63:0] p;
      p = '0;
      for (int i = 0; i < W; i++)
         if (b[i]) p ^= {32'd0, a} << i;
      return p;
   endfunction

   function automatic logic [31:0] poly_gcd_bezout(logic [31:0] a, logic [31:0] b,
                                                   output logic [31:0] u,
                                                   output logic [31:0] v);
      logic [31:0] u0, v0, u1, v1, q, r, t;
      logic [63:0] pq;
      u0 = 1; v0 = 0; u1 = 0; v1 = 1;
      while (b != 0) begin
         poly_divide(a, b, q, r);
         a = b;
         b = r;
         pq = clmul(q, u1);
         t = u1; u1 = u0 ^ pq[31:0]; u0 = t;
         pq = clmul(q, v1);
         t = v1; v1 = v0 ^ pq[31:0]; v0 = t;
      end
      u = u0;
      v = v0;
      return a;
   endfunction

   // a*b mod n, full product reduced (n has degree up to 31)
   function automatic logic [31:0] poly_mulmod(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] n);
      logic [63:0] p;
      logic [63:0] nn;
      int dn;
      dn = poly_degree(n);
      p = clmul(a, b);
      nn = {32'd0, n};
      for (int i = 63; i >= dn; i--)
         if (p[i]) p ^= nn << (i - dn);
      return p[31:0];
   endfunction

   function automatic logic poly_inverse(logic [31:0] a, logic [31:0] n,
                                         output logic [31:0] inv);
      logic [31:0] u, v, g;
      g = poly_gcd_bezout(poly_rem(a, n), n, u, v);
      inv = '0;
      if (g != 1) return 1'b0;
      inv = poly_rem(u, n);
      return 1'b1;
   endfunction

   function automatic gf2pa_pkg::rsp_type predict_alu(gf2pa_pkg::req_type rq);
      gf2pa_pkg::rsp_type rs;
      logic [63:0] prod;
      logic [31:0] a, b, inv, q, r;
      rs = '0;
      a = rq.operand_a;
      b = rq.operand_b;
      if (rq.opcode >= gf2pa_pkg::OP_MOD && rq.opcode <= gf2pa_pkg::OP_DIVMOD
          && modulus_reg == 0) begin
         rs.status = gf2pa_pkg::STATUS_MOD_ZERO;
      end else begin
         case (rq.opcode)
            gf2pa_pkg::OP_ADD: rs.result_first = a ^ b;
            gf2pa_pkg::OP_MUL: begin
               prod = clmul(a, b);
               rs.result_first = prod[31:0];
               rs.result_second = prod[63:32];
            end
            gf2pa_pkg::OP_DIV: begin
               if (b == 0) begin
                  rs.result_first = '1;
                  rs.status = gf2pa_pkg::STATUS_DIV_ZERO;
               end else begin
                  poly_divide(a, b, q, r);
                  rs.result_first = q;
                  rs.result_second = r;
               end
            end
            gf2pa_pkg::OP_GCD: rs.result_first = poly_gcd_bezout(a, b, q, r);
            gf2pa_pkg::OP_EXTGCD: rs.result_first = poly_gcd_bezout(a, b, rs.result_second,
                                                                    rs.result_third);
            gf2pa_pkg::OP_MOD: rs.result_first = poly_rem(a, modulus_reg);
            gf2pa_pkg::OP_ADDMOD: rs.result_first = poly_rem(a ^ b, modulus_reg);
            gf2pa_pkg::OP_MULMOD: rs.result_first = poly_mulmod(a, b, modulus_reg);
            gf2pa_pkg::OP_INV: begin
               if (poly_inverse(a, modulus_reg, inv)) rs.result_first = inv;
               else rs.status = gf2pa_pkg::STATUS_NOT_INV;
            end
            gf2pa_pkg::OP_DIVMOD: begin
               if (poly_inverse(b, modulus_reg, inv))
                  rs.result_first = poly_mulmod(a, inv, modulus_reg);
               else rs.status = gf2pa_pkg::STATUS_NOT_INV;
            end
            default: ;
         endcase
      end
      return rs;
   endfunction

   // ---------------- response checker ----------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_count <= rsp_count + 1;
         if (expected_rsp_q.size() == 0) begin
            $display("%0t unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            gf2pa_pkg::rsp_type e;
            e = expected_rsp_q.pop_front();
            if (rsp_data.result_first !== e.result_first) begin
               $display("%0t result_first exp %h got %h", $time, e.result_first,
                        rsp_data.result_first);
               error_count++;
            end
            if (rsp_data.result_second !== e.result_second) begin
               $display("%0t result_second exp %h got %h", $time, e.result_second,
                        rsp_data.result_second);
               error_count++;
            end
            if (rsp_data.result_third !== e.result_third) begin
               $display("%0t result_third exp %h got %h", $time, e.result_third,
                        rsp_data.result_third);
               error_count++;
            end
            if (rsp_data.status !== e.status) begin
               $display("%0t status exp %0d got %0d", $time, e.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // ---------------- driver ----------------
   // start stays high after an accept; it is dropped by an idle cycle or a drain
   task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
      gf2pa_pkg::req_type rq;
      rq.opcode = op;
      rq.operand_a = a;
      rq.operand_b = b;
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= rq;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      expected_rsp_q.push_back(predict_alu(rq));
      req_count++;
      op_hits[op]++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_modulus(logic [31:0] m);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      modulus_reg = m;
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [31:0] rand_poly();
      case ($urandom_range(5))
         0: return $urandom_range(15);
         1: return $urandom & ((32'd1 << $urandom_range(31)) - 1);
         2: return 32'h8000_0000 | $urandom;
         default: return $urandom;
      endcase
   endfunction

   // ---------------- tests ----------------
   task automatic test_unset_modulus();
      for (int op = gf2pa_pkg::OP_MOD; op <= gf2pa_pkg::OP_DIVMOD; op++)
         send_request(op[3:0], $urandom, $urandom);
   endtask

   task automatic test_directed();
      send_request(gf2pa_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0);
      send_request(gf2pa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(gf2pa_pkg::OP_DIV, 32'h1234_5678, 32'h0);
      send_request(gf2pa_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h1);
      send_request(gf2pa_pkg::OP_GCD, 32'h0, 32'h0);
      send_request(gf2pa_pkg::OP_EXTGCD, 32'h0, 32'h0);
      send_request(gf2pa_pkg::OP_EXTGCD, 32'hABCD, 32'h0);
      send_request(gf2pa_pkg::OP_EXTGCD, 32'hF0F0_1357, 32'h0000_0B1D);
      send_request(4'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(4'd15, 32'h1, 32'h1);
      write_modulus(32'h1); // modulus one: everything reduces to zero
      for (int op = gf2pa_pkg::OP_MOD; op <= gf2pa_pkg::OP_DIVMOD; op++)
         send_request(op[3:0], 32'hDEAD_BEEF, 32'h5);
      write_modulus(32'h8000_0000 | 32'h0040_0007);
      send_request(gf2pa_pkg::OP_INV, 32'h0, 32'h0);          // zero has no inverse
      send_request(gf2pa_pkg::OP_DIVMOD, 32'h55, 32'h0);
      send_request(gf2pa_pkg::OP_MULMOD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(gf2pa_pkg::OP_INV, 32'h2, 32'h0);
      write_modulus(32'h6);                        // X^2+X: X not invertible
      send_request(gf2pa_pkg::OP_INV, 32'h2, 32'h0);
      send_request(gf2pa_pkg::OP_DIVMOD, 32'h3, 32'h3);
   endtask

   task automatic test_random(int count);
      logic [3:0] op;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(19) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(9));
         send_request(op, rand_poly(), rand_poly());
      end
   endtask

   task automatic test_modulus_sweep();
      logic [31:0] mods[5];
      mods = '{32'hFFFF_FFFF, 32'h0000_0013, 32'h8000_0000, 32'h0000_011B, 32'h0};
      foreach (mods[k]) begin
         write_modulus(mods[k]);
         test_random(20);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      modulus_reg = '0;
      foreach (op_hits[i]) op_hits[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unset_modulus();
      test_directed();
      send_idle_pct = 21;
      write_modulus(32'h0000_0025);
      test_random(120);
      wait_drained();  // sender holds off until all responses are back
      send_idle_pct = 69;
      write_modulus(32'hC000_0001 | ($urandom & 32'h3FFF_FFFE));
      test_random(100);
      send_idle_pct = 0;
      test_modulus_sweep();
      write_modulus($urandom | 32'h1);
      test_random(130);

      wait_drained();
      repeat (200) @(posedge clock);
      $display("covered %0d requests, %0d responses, all ten opcodes plus unused codes",
               req_count, rsp_count);
      $display("modulus: unset, one, extremes and random; idle rates 21, 69 and 0 percent");
      if (error_count == 0 && expected_rsp_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/gf2pa_pkg.sv
rtl/core/gf2_polynomial_alu_unit.sv
verif/tb_gf2_polynomial_alu_unit.sv
